FILE: rtl/core/dsa_pkg.sv
// Shared types and constants for the delta script applier.
// No dependencies; used by dsa_core and delta_script_apply.
package dsa_pkg;

    localparam int COUNT_CHARS = 7;
    localparam int CNT_W       = 24;
    localparam int CHARS_W     = $clog2(COUNT_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [CNT_W-1:0] COPY_CAP = CNT_W'(256);

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_COPY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_WRONG = 2'd1,
        ERR_LONG  = 2'd2
    } err_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       want_base;
        logic       done_res;
        err_t       error_code;
    } result_t;

endpackage

FILE: rtl/core/dsa_core.sv
// Script decoder: phase, count and end-of-run state plus the per-byte step logic.
// Depends on dsa_pkg.
module dsa_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  dsa_pkg::item_t  item,
    output dsa_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_CMD   = 3'd0,
        PH_COUNT = 3'd1,
        PH_LIT   = 3'd2,
        PH_SKIP  = 3'd3,
        PH_DEL   = 3'd4,
        PH_COPY  = 3'd5
    } phase_t;

    localparam int MUL_W = dsa_pkg::CNT_W + 4;
    localparam logic [dsa_pkg::CNT_W-1:0] MUL_LIMIT = dsa_pkg::CNT_MAX / 10;

    phase_t                         phase_reg,   phase_next;
    dsa_pkg::kind_t                 kind_reg,    kind_next;
    logic [dsa_pkg::CNT_W-1:0]      count_reg,   count_next;
    logic [dsa_pkg::CHARS_W-1:0]    chars_reg,   chars_next;
    logic                           stopped_reg, stopped_next;
    logic                           finished_reg, finished_next;

    logic                           base_phase;
    logic [7:0]                     term;
    logic [7:0]                     digit;
    logic [MUL_W-1:0]               prod;
    logic [dsa_pkg::CNT_W-1:0]      count_dec;

    always_comb begin
        base_phase = (phase_reg == PH_DEL) || (phase_reg == PH_COPY);
        term       = (kind_reg == dsa_pkg::KIND_ADD) ? dsa_pkg::CH_SPACE : dsa_pkg::CH_NL;
        digit      = item.data_byte - dsa_pkg::CH_ZERO;
        // count * 10 + digit, wide enough that it cannot wrap
        prod       = MUL_W'({count_reg, 3'b000}) + MUL_W'({count_reg, 1'b0})
                   + MUL_W'(digit[3:0]);
        count_dec  = count_reg - dsa_pkg::CNT_W'(1);

        phase_next    = phase_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        chars_next    = chars_reg;
        stopped_next  = stopped_reg;
        finished_next = finished_reg;

        res            = '0;
        res.error_code = dsa_pkg::ERR_OK;

        if (finished_reg) begin
            // run over: input ignored
        end else if (!item.operation && item.stream_end) begin
            finished_next = 1'b1;
        end else if (item.operation != base_phase) begin
            res.error_code = dsa_pkg::ERR_WRONG;
        end else begin
            case (phase_reg)
                PH_CMD: begin
                    if (item.data_byte == dsa_pkg::CH_PLUS ||
                        item.data_byte == dsa_pkg::CH_MINUS ||
                        item.data_byte == dsa_pkg::CH_DOT) begin
                        kind_next    = (item.data_byte == dsa_pkg::CH_PLUS)  ? dsa_pkg::KIND_ADD :
                                       (item.data_byte == dsa_pkg::CH_MINUS) ? dsa_pkg::KIND_DEL :
                                                                               dsa_pkg::KIND_COPY;
                        count_next   = '0;
                        chars_next   = '0;
                        stopped_next = 1'b0;
                        phase_next   = PH_COUNT;
                    end else begin
                        finished_next = 1'b1;
                    end
                end
                PH_COUNT: begin
                    if (item.data_byte == term) begin
                        case (kind_reg)
                            dsa_pkg::KIND_ADD: phase_next = (count_reg != '0) ? PH_LIT : PH_SKIP;
                            dsa_pkg::KIND_DEL: phase_next = (count_reg != '0) ? PH_DEL : PH_CMD;
                            default: begin
                                // copy n+1 bytes, but exactly n for n of 256 or of CNT_MAX
                                if (count_reg != dsa_pkg::COPY_CAP &&
                                    count_reg != dsa_pkg::CNT_MAX) begin
                                    count_next = count_reg + dsa_pkg::CNT_W'(1);
                                end
                                phase_next = PH_COPY;
                            end
                        endcase
                    end else if (chars_reg >= dsa_pkg::CHARS_W'(dsa_pkg::COUNT_CHARS)) begin
                        res.error_code = dsa_pkg::ERR_LONG;
                    end else begin
                        chars_next = chars_reg + dsa_pkg::CHARS_W'(1);
                        if (!stopped_reg && item.data_byte >= dsa_pkg::CH_ZERO &&
                            item.data_byte <= dsa_pkg::CH_NINE) begin
                            if (count_reg > MUL_LIMIT || prod > MUL_W'(dsa_pkg::CNT_MAX)) begin
                                count_next = dsa_pkg::CNT_MAX;
                            end else begin
                                count_next = prod[dsa_pkg::CNT_W-1:0];
                            end
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                PH_LIT: begin
                    res.emit     = 1'b1;
                    res.out_byte = item.data_byte;
                    count_next   = count_dec;
                    if (count_dec == '0) phase_next = PH_SKIP;
                end
                PH_SKIP: begin
                    phase_next = PH_CMD;
                end
                PH_DEL: begin
                    count_next = count_dec;
                    if (count_dec == '0) phase_next = PH_CMD;
                end
                PH_COPY: begin
                    res.emit     = 1'b1;
                    res.out_byte = item.data_byte;
                    count_next   = count_dec;
                    if (count_dec == '0) phase_next = PH_CMD;
                end
                default: begin
                    phase_next = PH_CMD;
                end
            endcase
        end

        res.want_base = !finished_next && (phase_next == PH_DEL || phase_next == PH_COPY);
        res.done_res  = finished_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CMD;
            kind_reg     <= dsa_pkg::KIND_ADD;
            count_reg    <= '0;
            chars_reg    <= '0;
            stopped_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            count_reg    <= count_next;
            chars_reg    <= chars_next;
            stopped_reg  <= stopped_next;
            finished_reg <= finished_next;
        end
    end

    // end of run is sticky until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("finished flag dropped");

    // count never exceeds the allowed character count
    assert property (@(posedge aclk) disable iff (!aresetn)
        chars_reg <= dsa_pkg::CHARS_W'(dsa_pkg::COUNT_CHARS))
        else $error("count character tally out of range");

    // a byte is emitted only on a clean, live step
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.emit |-> (res.error_code == dsa_pkg::ERR_OK && !res.done_res))
        else $error("emit with error or after end");

    // literal, delete and copy phases always hold a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LIT || phase_reg == PH_COPY || phase_reg == PH_DEL) |-> count_reg != '0)
        else $error("zero count in a transfer phase");

endmodule

FILE: rtl/core/delta_script_apply.sv
// Top level of the delta script applier: input register, decoder core, result register.
// Depends on dsa_pkg and dsa_core.
//
//  channel | ports                                             | direction
//  s_      | s_operation, s_data_byte, s_stream_end            | in  (valid/ready)
//  m_      | m_emit, m_out_byte, m_want_base, m_done_res,      | out (valid/ready)
//          | m_error_code                                      |
//
// One byte per cycle sustained while m_ready stays high; a byte taken in goes to the
// input register and, on a step of the core, to the result register, which drives m_valid.
// The phase/count update for a byte is a single step of dsa_core between the
// input register and the result register.
// Reset (aresetn low, synchronous) empties both registers and puts the core
// back to awaiting a command. A stalled result holds the pipe; s_ready drops
// only when both registers are full and m_ready is low.
module delta_script_apply (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_data_byte,
    input  logic       s_stream_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_emit,
    output logic [7:0] m_out_byte,
    output logic       m_want_base,
    output logic       m_done_res,
    output logic [1:0] m_error_code
);

    logic             in_valid_reg;
    dsa_pkg::item_t   in_item_reg;
    logic             m_valid_reg;
    dsa_pkg::result_t res_reg;
    dsa_pkg::result_t res_next;
    logic             out_ready;
    logic             step;

    assign out_ready = !m_valid_reg || m_ready;
    assign step      = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    dsa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.operation  <= s_operation;
            in_item_reg.data_byte  <= s_data_byte;
            in_item_reg.stream_end <= s_stream_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_emit       = res_reg.emit;
    assign m_out_byte   = res_reg.out_byte;
    assign m_want_base  = res_reg.want_base;
    assign m_done_res   = res_reg.done_res;
    assign m_error_code = res_reg.error_code;

    // a result leaves the register only through a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid_reg) |-> $past(m_ready))
        else $error("result dropped without transfer");

    // input side stalls only when both stages are occupied and blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled needlessly");

endmodule

FILE: tb/delta_script_apply_test.sv
// Self-checking testbench for delta_script_apply: one long delta script with base bytes,
// random idling on both channels, results checked against an in-bench decoder model.
// Depends on dsa_pkg and the delta_script_apply RTL.
module delta_script_apply_test;

    typedef enum logic [2:0] {
        AWAIT_CMD, READ_COUNT, ADD_LIT, ADD_SKIP, DROP_BASE, COPY_BASE
    } dec_phase_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_operation = 1'b0;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_stream_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_emit;
    logic [7:0] m_out_byte;
    logic       m_want_base;
    logic       m_done_res;
    logic [1:0] m_error_code;

    delta_script_apply u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_data_byte (s_data_byte),
        .s_stream_end(s_stream_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_emit      (m_emit),
        .m_out_byte  (m_out_byte),
        .m_want_base (m_want_base),
        .m_done_res  (m_done_res),
        .m_error_code(m_error_code)
    );

    // decoder model state
    dec_phase_t                  dec_phase = AWAIT_CMD;
    dsa_pkg::kind_t              dec_kind = dsa_pkg::KIND_ADD;
    logic [dsa_pkg::CNT_W-1:0]   dec_count = '0;
    logic [dsa_pkg::CHARS_W-1:0] dec_chars = '0;
    logic                        dec_stopped = 1'b0;
    logic                        dec_done = 1'b0;

    dsa_pkg::item_t   byte_feed[$];
    dsa_pkg::result_t rebuilt_q[$];
    dsa_pkg::item_t   next_byte;
    int      noise_pct = 0;
    int      total_items = 0;
    int      accepted = 0;
    int      checked = 0;
    int      fails = 0;
    int      send_gap = 0;
    int      hold_left = 0;
    bit      long_hold_done = 1'b0;

    function automatic dsa_pkg::result_t apply_script_byte(logic op, logic [7:0] b, logic eos);
        dsa_pkg::result_t r;
        logic [7:0]  term;
        logic [31:0] v;
        logic        in_base;
        r = '0;
        r.error_code = dsa_pkg::ERR_OK;
        in_base = (dec_phase == DROP_BASE || dec_phase == COPY_BASE);
        if (dec_done) begin
            // ignored once the run has ended
        end else if (!op && eos) begin
            dec_done = 1'b1;
        end else if (op != in_base) begin
            r.error_code = dsa_pkg::ERR_WRONG;
        end else begin
            case (dec_phase)
                AWAIT_CMD: begin
                    if (b == dsa_pkg::CH_PLUS || b == dsa_pkg::CH_MINUS ||
                        b == dsa_pkg::CH_DOT) begin
                        dec_kind = (b == dsa_pkg::CH_PLUS) ? dsa_pkg::KIND_ADD :
                                   (b == dsa_pkg::CH_MINUS) ? dsa_pkg::KIND_DEL :
                                                              dsa_pkg::KIND_COPY;
                        dec_count = '0;
                        dec_chars = '0;
                        dec_stopped = 1'b0;
                        dec_phase = READ_COUNT;
                    end else begin
                        dec_done = 1'b1;
                    end
                end
                READ_COUNT: begin
                    term = (dec_kind == dsa_pkg::KIND_ADD) ? dsa_pkg::CH_SPACE : dsa_pkg::CH_NL;
                    if (b == term) begin
                        if (dec_kind == dsa_pkg::KIND_ADD) begin
                            dec_phase = (dec_count != 0) ? ADD_LIT : ADD_SKIP;
                        end else if (dec_kind == dsa_pkg::KIND_DEL) begin
                            dec_phase = (dec_count != 0) ? DROP_BASE : AWAIT_CMD;
                        end else begin
                            if (dec_count != dsa_pkg::COPY_CAP && dec_count < dsa_pkg::CNT_MAX)
                                dec_count = dec_count + 1'b1;
                            dec_phase = COPY_BASE;
                        end
                    end else if (dec_chars >= dsa_pkg::COUNT_CHARS) begin
                        r.error_code = dsa_pkg::ERR_LONG;
                    end else begin
                        dec_chars = dec_chars + 1'b1;
                        if (!dec_stopped && b >= dsa_pkg::CH_ZERO && b <= dsa_pkg::CH_NINE) begin
                            v = 32'(dec_count) * 10 + 32'(b - dsa_pkg::CH_ZERO);
                            if (dec_count > dsa_pkg::CNT_MAX / 10 ||
                                v > 32'(dsa_pkg::CNT_MAX))
                                v = 32'(dsa_pkg::CNT_MAX);
                            dec_count = v[dsa_pkg::CNT_W-1:0];
                        end else begin
                            dec_stopped = 1'b1;
                        end
                    end
                end
                ADD_LIT: begin
                    r.emit = 1'b1;
                    r.out_byte = b;
                    dec_count = dec_count - 1'b1;
                    if (dec_count == 0) dec_phase = ADD_SKIP;
                end
                ADD_SKIP: dec_phase = AWAIT_CMD;
                DROP_BASE: begin
                    dec_count = dec_count - 1'b1;
                    if (dec_count == 0) dec_phase = AWAIT_CMD;
                end
                COPY_BASE: begin
                    r.emit = 1'b1;
                    r.out_byte = b;
                    dec_count = dec_count - 1'b1;
                    if (dec_count == 0) dec_phase = AWAIT_CMD;
                end
                default: dec_phase = AWAIT_CMD;
            endcase
        end
        r.want_base = !dec_done && (dec_phase == DROP_BASE || dec_phase == COPY_BASE);
        r.done_res = dec_done;
        return r;
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic void put(logic op, logic [7:0] b, logic eos);
        dsa_pkg::item_t it;
        it.operation = op;
        it.data_byte = b;
        it.stream_end = eos;
        byte_feed.push_back(it);
    endfunction

    // a stray byte from the other stream may precede any expected byte
    function automatic void put_script(logic [7:0] b);
        if ($urandom_range(0, 99) < noise_pct)
            put(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
        put(1'b0, b, 1'b0);
    endfunction

    function automatic void put_base(logic [7:0] b);
        if ($urandom_range(0, 99) < noise_pct)
            put(1'b0, 8'($urandom), 1'b0);
        put(1'b1, b, 1'($urandom_range(0, 1)));
    endfunction

    // count text: optional leading zeros, digits, optional trailing junk
    function automatic void put_count(logic [7:0] term, int value);
        logic [7:0] digs[$];
        logic [7:0] j;
        int         x;
        int         n;
        x = value;
        do begin
            digs.push_front(8'(dsa_pkg::CH_ZERO + x % 10));
            x = x / 10;
        end while (x > 0);
        if (value == 0 && $urandom_range(0, 3) == 0)
            digs.delete();
        if (digs.size() < dsa_pkg::COUNT_CHARS && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, dsa_pkg::COUNT_CHARS - digs.size());
            repeat (n) digs.push_front(dsa_pkg::CH_ZERO);
        end
        foreach (digs[i]) put_script(digs[i]);
        if ($urandom_range(0, 3) == 0) begin
            // junk may run past the character limit
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                do j = 8'($urandom);
                while (j == term ||
                       (k == 0 && j >= dsa_pkg::CH_ZERO && j <= dsa_pkg::CH_NINE));
                put_script(j);
            end
        end
        put_script(term);
    endfunction

    function automatic void add_cmd(int value);
        put_script(dsa_pkg::CH_PLUS);
        put_count(dsa_pkg::CH_SPACE, value);
        repeat (value) put_script(8'($urandom));
        put_script(8'($urandom));
    endfunction

    function automatic void del_cmd(int value);
        put_script(dsa_pkg::CH_MINUS);
        put_count(dsa_pkg::CH_NL, value);
        repeat (value) put_base(8'($urandom));
    endfunction

    function automatic void copy_cmd(int value);
        put_script(dsa_pkg::CH_DOT);
        put_count(dsa_pkg::CH_NL, value);
        repeat ((value == 256) ? 256 : value + 1) put_base(8'($urandom));
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 92) return $urandom_range(9, 40);
        if (r < 98) return $urandom_range(41, 300);
        return $urandom_range(255, 257);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report(string what, int got, int want);
        fails++;
        $display("mismatch at result %0d: %s got 'h%0h expected 'h%0h",
                 checked, what, got, want);
    endtask

    // ---------------- clock, reset, timeout ----------------
    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            dec_phase = AWAIT_CMD;
            dec_kind = dsa_pkg::KIND_ADD;
            dec_count = '0;
            dec_chars = '0;
            dec_stopped = 1'b0;
            dec_done = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rebuilt_q.push_back(apply_script_byte(s_operation, s_data_byte, s_stream_end));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (byte_feed.size() > 0) begin
                    next_byte = byte_feed.pop_front();
                    s_operation <= next_byte.operation;
                    s_data_byte <= next_byte.data_byte;
                    s_stream_end <= next_byte.stream_end;
                    s_valid <= 1'b1;
                    send_gap = ((accepted % 256) < 48) ? 0 : idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        dsa_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rebuilt_q.size() == 0) begin
                    report("result with nothing pending, out_byte", m_out_byte, 0);
                end else begin
                    want = rebuilt_q.pop_front();
                    if (m_emit !== want.emit) report("emit", m_emit, want.emit);
                    if (m_out_byte !== want.out_byte)
                        report("out_byte", m_out_byte, want.out_byte);
                    if (m_want_base !== want.want_base)
                        report("want_base", m_want_base, want.want_base);
                    if (m_done_res !== want.done_res)
                        report("done_res", m_done_res, want.done_res);
                    if (m_error_code !== 2'(want.error_code))
                        report("error_code", m_error_code, want.error_code);
                end
                checked++;
            end
            // one long back-pressure stretch so the pipe fills and s_ready drops
            if (!long_hold_done && checked >= 400) begin
                long_hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left == 0 && !((checked % 256) >= 128 && (checked % 256) < 176))
                hold_left = idle_len();
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        logic [7:0] j;
        // directed: zero counts, wrong stream, junk after digits
        put(1'b0, dsa_pkg::CH_PLUS, 1'b0); put(1'b0, dsa_pkg::CH_SPACE, 1'b0);
        put(1'b0, 8'h00, 1'b0);
        put(1'b0, dsa_pkg::CH_MINUS, 1'b0); put(1'b0, dsa_pkg::CH_ZERO, 1'b0);
        put(1'b0, dsa_pkg::CH_NL, 1'b0);
        put(1'b0, dsa_pkg::CH_DOT, 1'b0); put(1'b0, dsa_pkg::CH_ZERO, 1'b0);
        put(1'b0, dsa_pkg::CH_NL, 1'b0);
        put(1'b1, 8'hFF, 1'b1);
        put(1'b1, 8'hA5, 1'b1);
        put(1'b0, dsa_pkg::CH_PLUS, 1'b0); put(1'b0, "2", 1'b0);
        put(1'b0, dsa_pkg::CH_SPACE, 1'b0);
        put(1'b0, 8'h00, 1'b0); put(1'b0, 8'hFF, 1'b0); put(1'b0, dsa_pkg::CH_NL, 1'b0);
        put(1'b0, dsa_pkg::CH_MINUS, 1'b0); put(1'b0, "1", 1'b0); put(1'b0, "x", 1'b0);
        put(1'b0, "9", 1'b0); put(1'b0, dsa_pkg::CH_NL, 1'b0);
        put(1'b0, 8'h33, 1'b0); put(1'b1, 8'h5A, 1'b0);

        // random: well-formed commands with stray bytes mixed in
        noise_pct = 6;
        copy_cmd(256);
        copy_cmd(255);
        while (byte_feed.size() < 1120) begin
            case ($urandom_range(0, 2))
                0: add_cmd(pick_count());
                1: del_cmd(pick_count());
                default: copy_cmd(pick_count());
            endcase
        end

        // end the run in one of several ways, then bytes that must be ignored
        case ($urandom_range(0, 3))
            0: put(1'b0, 8'($urandom), 1'b1);
            1: begin
                do j = 8'($urandom);
                while (j == dsa_pkg::CH_PLUS || j == dsa_pkg::CH_MINUS || j == dsa_pkg::CH_DOT);
                put(1'b0, j, 1'b0);
            end
            2: begin
                put_script(dsa_pkg::CH_DOT);
                put_count(dsa_pkg::CH_NL, 9999999);
                repeat (5) put_base(8'($urandom));
                put(1'b0, 8'($urandom), 1'b1);
            end
            default: begin
                put_script(dsa_pkg::CH_PLUS);
                put_count(dsa_pkg::CH_SPACE, 5);
                repeat (2) put_script(8'($urandom));
                put(1'b0, 8'($urandom), 1'b1);
            end
        endcase
        repeat (12) put(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
        total_items = byte_feed.size();

        do @(negedge aclk);
        while (accepted < total_items || rebuilt_q.size() != 0);
        repeat (8) @(negedge aclk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
